@@ rtl/core/pfr_pkg.sv @@
`default_nettype none
package pfr_pkg;

    localparam int NUM_TAPS   = 32;
    localparam int PHASES     = 128;
    localparam int CHANNELS   = 2;
    localparam int HALF_TAPS  = NUM_TAPS / 2;
    localparam int HIST_DEPTH = 64;
    localparam int HIST_AW    = 6;
    localparam int COEF_DEPTH = (PHASES + 1) * NUM_TAPS;
    localparam int COEF_AW    = 13;
    localparam int FRAC_BITS  = 28;
    localparam int PH_W       = $clog2(PHASES + 1);
    localparam int TAP_W      = $clog2(NUM_TAPS);
    localparam int SMP_W      = 24;
    localparam int COEF_W     = 25;
    localparam int ACC_W      = SMP_W + COEF_W + $clog2(NUM_TAPS);
    localparam int MAX_OUT    = 16;
    localparam int CNT_W      = 5;
    localparam int FED_W      = 36;
    localparam int POS_W      = 64;
    localparam int AB_W       = FED_W + 2;
    localparam int PIPE_DEPTH = 5;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_FLUSH = 2'd1;
    localparam logic [1:0] CMD_COEF  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic REG_STEP   = 1'b0;
    localparam logic REG_BYPASS = 1'b1;

    typedef struct packed {
        logic [HIST_AW-1:0] addr;
        logic               ok;
    } hist_rd_t;

    typedef struct packed {
        logic vld;
        logic clr;
        logic fin;
    } tap_ctl_t;

    typedef struct packed {
        logic [COEF_AW-1:0] addr0;
        logic [COEF_AW-1:0] addr1;
    } coef_rd_t;

endpackage
`default_nettype wire

@@ rtl/core/pfr_coef.sv @@
`default_nettype none
module pfr_coef
(
    input  wire logic                              clk,
    input  wire logic                              wr_en,
    input  wire logic [pfr_pkg::COEF_AW-1:0]       wr_addr,
    input  wire logic signed [pfr_pkg::SMP_W-1:0]  wr_data,
    input  wire pfr_pkg::coef_rd_t                 rd,
    input  wire logic [pfr_pkg::FRAC_BITS-1:0]     sub,
    output logic signed [pfr_pkg::COEF_W-1:0]      coef
);
    import pfr_pkg::*;

    localparam int MUL_W = COEF_W + FRAC_BITS + 1;

    logic signed [SMP_W-1:0]  mem [COEF_DEPTH];
    logic signed [SMP_W-1:0]  c0_reg;
    logic signed [SMP_W-1:0]  c1_reg;
    logic signed [SMP_W-1:0]  c0d_reg;
    logic signed [MUL_W-1:0]  mul_reg;
    logic signed [COEF_W-1:0] coef_reg;
    logic signed [COEF_W-1:0] diff;
    logic signed [MUL_W-1:0]  mul_next;
    logic signed [MUL_W-1:0]  rnd;
    logic signed [COEF_W-1:0] coef_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        c0_reg <= mem[rd.addr0];
        c1_reg <= mem[rd.addr1];
    end

    always_comb
    begin
        diff      = COEF_W'(c1_reg) - COEF_W'(c0_reg);
        mul_next  = MUL_W'(diff) * $signed({1'b0, sub});
        rnd       = (mul_reg + (MUL_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        coef_next = COEF_W'(c0d_reg) + rnd[COEF_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        c0d_reg  <= c0_reg;
        mul_reg  <= mul_next;
        coef_reg <= coef_next;
    end

    assign coef = coef_reg;

endmodule
`default_nettype wire

@@ rtl/core/pfr_lane.sv @@
`default_nettype none
module pfr_lane
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              wr_en,
    input  wire logic [pfr_pkg::HIST_AW-1:0]       wr_addr,
    input  wire logic signed [pfr_pkg::SMP_W-1:0]  wr_data,
    input  wire logic                              clr,
    input  wire pfr_pkg::hist_rd_t                 rd,
    input  wire logic signed [pfr_pkg::COEF_W-1:0] coef,
    input  wire pfr_pkg::tap_ctl_t                 ctl,
    output logic signed [pfr_pkg::SMP_W-1:0]       result
);
    import pfr_pkg::*;

    localparam int PROD_W = SMP_W + COEF_W;

    logic signed [SMP_W-1:0]  mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0]    hv_reg;
    logic signed [SMP_W-1:0]  rdq_reg;
    logic                     ok_reg;
    logic signed [SMP_W-1:0]  s2_reg;
    logic signed [SMP_W-1:0]  s3_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  rnd;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdq_reg <= mem[rd.addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv_reg <= '0;
            ok_reg <= 1'b0;
        end
        else
        begin
            if (clr)
            begin
                hv_reg <= '0;
            end
            else if (wr_en)
            begin
                hv_reg[wr_addr] <= 1'b1;
            end
            ok_reg <= rd.ok & hv_reg[rd.addr];
        end
    end

    always_comb
    begin
        acc_next = ctl.clr ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
        rnd      = (acc_reg + (ACC_W'(1) <<< 21)) >>> 22;
        if (rnd > ACC_W'(8388607))
        begin
            result = 24'sh7FFFFF;
        end
        else if (rnd < -ACC_W'(8388608))
        begin
            result = 24'sh800000;
        end
        else
        begin
            result = rnd[SMP_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        s2_reg   <= ok_reg ? rdq_reg : '0;
        s3_reg   <= s2_reg;
        prod_reg <= PROD_W'(s3_reg) * PROD_W'(coef);
        if (ctl.vld)
        begin
            acc_reg <= acc_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/polyphase_fractional_resampler_unit.sv @@
`default_nettype none
// Coefficient writes and clears complete on acceptance. A push computes its
// output words one tap per cycle per lane, with the coefficient read port
// shared by both lanes; a new word is accepted only once every output word of
// the previous push, or its bypass word, has been loaded to the output.
// Reset clears position, frame count and history valid bits; coefficients
// are not reset.
module polyphase_fractional_resampler_unit
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic                              cfg_index,
    input  wire logic [31:0]                       cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [1:0]                        cmd,
    input  wire logic signed [pfr_pkg::SMP_W-1:0]  sample_ch0,
    input  wire logic signed [pfr_pkg::SMP_W-1:0]  sample_ch1,
    input  wire logic [pfr_pkg::COEF_AW-1:0]       coef_addr,
    input  wire logic signed [pfr_pkg::SMP_W-1:0]  coef_value,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [pfr_pkg::SMP_W-1:0]       out_ch0,
    output logic signed [pfr_pkg::SMP_W-1:0]       out_ch1,
    output logic                                   last
);
    import pfr_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_ISSUE = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t                   state_reg;
    logic [31:0]              step_reg;
    logic                     bypass_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [FED_W-1:0]         fed_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [TAP_W-1:0]         k_reg;
    logic [AB_W-1:0]          ab_reg;
    logic                     byp_reg;
    logic signed [SMP_W-1:0]  byp0_reg;
    logic signed [SMP_W-1:0]  byp1_reg;
    tap_ctl_t                 pipe_reg [PIPE_DEPTH];
    logic                     ov_reg;
    logic signed [SMP_W-1:0]  o0_reg;
    logic signed [SMP_W-1:0]  o1_reg;
    logic                     olast_reg;

    logic                     accept;
    logic                     hist_wr;
    logic                     clr;
    logic                     load;
    logic [FED_W-1:0]         fl;
    logic [FRAC_BITS+PH_W-1:0] pp;
    logic [PH_W-1:0]          p0;
    logic [PH_W-1:0]          p1;
    logic [FRAC_BITS-1:0]     sub;
    coef_rd_t                 crd;
    hist_rd_t                 hrd;
    tap_ctl_t                 ictl;
    logic [AB_W-1:0]          fed_x;
    logic [POS_W-1:0]         pos_step;
    logic                     stop_now;
    logic                     stop_next;
    logic signed [COEF_W-1:0] coef;
    logic signed [SMP_W-1:0]  res [2];
    logic signed [SMP_W-1:0]  wsmp [2];

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign clr      = accept && (cmd == CMD_CLEAR);
    assign hist_wr  = accept && !bypass_reg && (cmd == CMD_PUSH || cmd == CMD_FLUSH);
    assign load     = (state_reg == ST_EMIT) && (!ov_reg || out_ready);

    always_comb
    begin
        fl       = pos_reg[POS_W-1:FRAC_BITS];
        pp       = (FRAC_BITS+PH_W)'(pos_reg[FRAC_BITS-1:0]) * (FRAC_BITS+PH_W)'(PHASES);
        p0       = pp[FRAC_BITS+PH_W-1:FRAC_BITS];
        p1       = p0 + PH_W'(1);
        sub      = pp[FRAC_BITS-1:0];
        crd.addr0 = COEF_AW'(p0) * COEF_AW'(NUM_TAPS) + COEF_AW'(k_reg);
        crd.addr1 = COEF_AW'(p1) * COEF_AW'(NUM_TAPS) + COEF_AW'(k_reg);
        fed_x    = AB_W'(fed_reg);
        hrd.addr = ab_reg[HIST_AW-1:0];
        hrd.ok   = !ab_reg[AB_W-1] && (ab_reg < fed_x)
                   && ((fed_x - ab_reg) <= AB_W'(HIST_DEPTH));
        ictl.vld = (state_reg == ST_ISSUE);
        ictl.clr = (k_reg == '0);
        ictl.fin = (k_reg == TAP_W'(NUM_TAPS - 1));
        pos_step = pos_reg + POS_W'(step_reg);
        stop_now = (cnt_reg == CNT_W'(MAX_OUT))
                   || ((AB_W'(fl) + AB_W'(HALF_TAPS)) >= fed_x);
        stop_next = (cnt_reg == CNT_W'(MAX_OUT - 1))
                   || ((AB_W'(pos_step[POS_W-1:FRAC_BITS]) + AB_W'(HALF_TAPS)) >= fed_x);
        wsmp[0]  = (cmd == CMD_FLUSH) ? '0 : sample_ch0;
        wsmp[1]  = (cmd == CMD_FLUSH) ? '0 : sample_ch1;
    end

    pfr_coef u_coef
    (
        .clk     (clk),
        .wr_en   (accept && (cmd == CMD_COEF) && (coef_addr < COEF_AW'(COEF_DEPTH))),
        .wr_addr (coef_addr),
        .wr_data (coef_value),
        .rd      (crd),
        .sub     (sub),
        .coef    (coef)
    );

    genvar c;
    generate
        for (c = 0; c < 2; c++)
        begin : g_lane
            if (c < CHANNELS)
            begin : g_on
                pfr_lane u_lane
                (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .wr_en   (hist_wr),
                    .wr_addr (fed_reg[HIST_AW-1:0]),
                    .wr_data (wsmp[c]),
                    .clr     (clr),
                    .rd      (hrd),
                    .coef    (coef),
                    .ctl     (pipe_reg[PIPE_DEPTH-2]),
                    .result  (res[c])
                );
            end
            else
            begin : g_off
                assign res[c] = '0;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= 32'd268435456;
            bypass_reg <= 1'b0;
            pos_reg    <= '0;
            fed_reg    <= '0;
            cnt_reg    <= '0;
            k_reg      <= '0;
            ab_reg     <= '0;
            byp_reg    <= 1'b0;
            ov_reg     <= 1'b0;
            for (int i = 0; i < PIPE_DEPTH; i++)
            begin
                pipe_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_STEP:   step_reg   <= cfg_data;
                    REG_BYPASS: bypass_reg <= cfg_data[0];
                    default:    ;
                endcase
            end

            pipe_reg[0] <= ictl;
            for (int i = 1; i < PIPE_DEPTH; i++)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end

            if (load)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (cmd == CMD_CLEAR)
                        begin
                            pos_reg <= '0;
                            fed_reg <= '0;
                        end
                        else if (cmd == CMD_PUSH && bypass_reg)
                        begin
                            fed_reg   <= fed_reg + FED_W'(1);
                            byp_reg   <= 1'b1;
                            state_reg <= ST_EMIT;
                        end
                        else if (hist_wr)
                        begin
                            fed_reg   <= fed_reg + FED_W'(1);
                            byp_reg   <= 1'b0;
                            cnt_reg   <= '0;
                            state_reg <= ST_CHECK;
                        end
                    end
                end
                ST_CHECK:
                begin
                    k_reg  <= '0;
                    ab_reg <= AB_W'(fl) - AB_W'(HALF_TAPS - 1);
                    state_reg <= stop_now ? ST_IDLE : ST_ISSUE;
                end
                ST_ISSUE:
                begin
                    k_reg  <= k_reg + TAP_W'(1);
                    ab_reg <= ab_reg + AB_W'(1);
                    if (ictl.fin)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (pipe_reg[PIPE_DEPTH-1].vld && pipe_reg[PIPE_DEPTH-1].fin)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (load)
                    begin
                        if (byp_reg)
                        begin
                            pos_reg   <= pos_reg + (POS_W'(1) << FRAC_BITS);
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            pos_reg   <= pos_step;
                            cnt_reg   <= cnt_reg + CNT_W'(1);
                            state_reg <= stop_next ? ST_IDLE : ST_CHECK;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byp0_reg <= sample_ch0;
            byp1_reg <= (CHANNELS > 1) ? sample_ch1 : '0;
        end
        if (load)
        begin
            o0_reg    <= byp_reg ? byp0_reg : res[0];
            o1_reg    <= byp_reg ? byp1_reg : res[1];
            olast_reg <= byp_reg || stop_next;
        end
    end

    assign out_valid = ov_reg;
    assign out_ch0   = o0_reg;
    assign out_ch1   = o1_reg;
    assign last      = olast_reg;

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
    import pfr_pkg::*;

    typedef struct {
        logic signed [SMP_W-1:0] ch0;
        logic signed [SMP_W-1:0] ch1;
        logic                    fin;
    } out_frame_t;

    class resampler_scoreboard;
        longint     hist_l[HIST_DEPTH];
        longint     hist_r[HIST_DEPTH];
        longint     coefs[COEF_DEPTH];
        logic [63:0] position;
        logic [35:0] fed;
        logic [31:0] step;
        logic        bypass_on;
        out_frame_t  pending_frames[$];
        int          errors;
        int          matched;

        function void reset_state();
            foreach (hist_l[i]) hist_l[i] = 0;
            foreach (hist_r[i]) hist_r[i] = 0;
            foreach (coefs[i]) coefs[i] = 0;
            position  = '0;
            fed       = '0;
            step      = 32'd268435456;
            bypass_on = 1'b0;
            errors    = 0;
            matched   = 0;
        endfunction

        function void write_reg(logic idx, logic [31:0] data);
            if (idx == REG_STEP)
                step = data;
            else
                bypass_on = data[0];
        endfunction

        function longint sat(longint v);
            if (v > 64'sd8388607)
                return 64'sd8388607;
            if (v < -64'sd8388608)
                return -64'sd8388608;
            return v;
        endfunction

        function longint filter_lane(bit right);
            longint fl, pp, p0, p1, sub, first, ab, s, c0, c1, c, acc, fedv;
            fl    = longint'(position >> FRAC_BITS);
            pp    = longint'(position[FRAC_BITS-1:0]) * PHASES;
            p0    = pp >>> FRAC_BITS;
            sub   = pp & ((longint'(1) <<< FRAC_BITS) - 1);
            p1    = (p0 + 1 < PHASES) ? p0 + 1 : PHASES;
            first = fl - HALF_TAPS + 1;
            fedv  = longint'(fed);
            acc   = 0;
            for (int k = 0; k < NUM_TAPS; k++)
            begin
                ab = first + k;
                s  = 0;
                c0 = coefs[p0 * NUM_TAPS + k];
                c1 = coefs[p1 * NUM_TAPS + k];
                c  = c0 + (((c1 - c0) * sub + (longint'(1) <<< 27)) >>> FRAC_BITS);
                if (ab >= 0 && ab < fedv && fedv - ab <= HIST_DEPTH)
                    s = right ? hist_r[ab % HIST_DEPTH] : hist_l[ab % HIST_DEPTH];
                acc += s * c;
            end
            return sat((acc + (longint'(1) <<< 21)) >>> 22);
        endfunction

        function void note_word(logic [1:0] c, logic signed [SMP_W-1:0] s0,
                                logic signed [SMP_W-1:0] s1, logic [COEF_AW-1:0] addr,
                                logic signed [SMP_W-1:0] val);
            out_frame_t f;
            logic [63:0] fl;
            int n;
            n = 0;
            if (c == CMD_COEF)
            begin
                if (addr < COEF_DEPTH)
                    coefs[addr] = val;
                return;
            end
            if (c == CMD_CLEAR)
            begin
                foreach (hist_l[i]) hist_l[i] = 0;
                foreach (hist_r[i]) hist_r[i] = 0;
                position = '0;
                fed      = '0;
                return;
            end
            if (bypass_on)
            begin
                if (c == CMD_FLUSH)
                    return;
                f.ch0 = s0;
                f.ch1 = s1;
                f.fin = 1'b1;
                pending_frames.push_back(f);
                position += 64'd1 << FRAC_BITS;
                fed      += 36'd1;
                return;
            end
            hist_l[fed[HIST_AW-1:0]] = (c == CMD_FLUSH) ? 0 : longint'(s0);
            hist_r[fed[HIST_AW-1:0]] = (c == CMD_FLUSH) ? 0 : longint'(s1);
            fed += 36'd1;
            while (n < MAX_OUT)
            begin
                fl = position >> FRAC_BITS;
                if (fl + 64'd16 >= {28'b0, fed})
                    break;
                f.ch0 = SMP_W'(filter_lane(1'b0));
                f.ch1 = SMP_W'(filter_lane(1'b1));
                f.fin = 1'b0;
                pending_frames.push_back(f);
                position += {32'b0, step};
                n++;
            end
            if (n > 0)
                pending_frames[pending_frames.size() - 1].fin = 1'b1;
        endfunction

        function void check_word(logic signed [SMP_W-1:0] o0, logic signed [SMP_W-1:0] o1,
                                 logic lst);
            out_frame_t e;
            if (pending_frames.size() == 0)
            begin
                $display("%0t: unexpected word ch0=%0d ch1=%0d last=%0b", $time, o0, o1, lst);
                errors++;
                return;
            end
            e = pending_frames.pop_front();
            matched++;
            if (o0 !== e.ch0)
            begin
                $display("%0t: out_ch0 expected %0d actual %0d", $time, e.ch0, o0);
                errors++;
            end
            if (o1 !== e.ch1)
            begin
                $display("%0t: out_ch1 expected %0d actual %0d", $time, e.ch1, o1);
                errors++;
            end
            if (lst !== e.fin)
            begin
                $display("%0t: last expected %0b actual %0b", $time, e.fin, lst);
                errors++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic                    cfg_index;
    logic [31:0]             cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic [1:0]              cmd;
    logic signed [SMP_W-1:0] sample_ch0;
    logic signed [SMP_W-1:0] sample_ch1;
    logic [COEF_AW-1:0]      coef_addr;
    logic signed [SMP_W-1:0] coef_value;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [SMP_W-1:0] out_ch0;
    logic signed [SMP_W-1:0] out_ch1;
    logic                    last;

    resampler_scoreboard sb;
    int send_idle;
    int recv_idle;
    int quiet_cycles = 0;
    int words_sent;

    polyphase_fractional_resampler_unit i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .sample_ch0 (sample_ch0),
        .sample_ch1 (sample_ch1),
        .coef_addr  (coef_addr),
        .coef_value (coef_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_ch0    (out_ch0),
        .out_ch1    (out_ch1),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_word(out_ch0, out_ch1, last);
    end

    // watchdog: cycles without any accepted word
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 50000)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_word(logic [1:0] c, logic signed [SMP_W-1:0] s0,
                             logic signed [SMP_W-1:0] s1, logic [COEF_AW-1:0] addr,
                             logic signed [SMP_W-1:0] val);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        cmd        = c;
        sample_ch0 = s0;
        sample_ch1 = s1;
        coef_addr  = addr;
        coef_value = val;
        in_valid   = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_word(c, s0, s1, addr, val);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (sb.pending_frames.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        drain();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic random_words(int count, int push_pct);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < push_pct)
                send_word(CMD_PUSH, SMP_W'($urandom), SMP_W'($urandom),
                          COEF_AW'($urandom), SMP_W'($urandom));
            else if (r < push_pct + (100 - push_pct) / 2)
                send_word(CMD_FLUSH, SMP_W'($urandom), SMP_W'($urandom),
                          COEF_AW'($urandom), SMP_W'($urandom));
            else if (r < 97)
                send_word(CMD_COEF, SMP_W'($urandom), SMP_W'($urandom),
                          COEF_AW'($urandom_range(8191)),
                          SMP_W'($urandom_range(4194303) - 2097152));
            else
                send_word(CMD_CLEAR, SMP_W'($urandom), SMP_W'($urandom),
                          COEF_AW'($urandom), SMP_W'($urandom));
        end
    endtask

    initial
    begin
        sb = new();
        sb.reset_state();
        send_idle    = 0;
        recv_idle    = 0;
        words_sent   = 0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_STEP;
        cfg_data     = '0;
        in_valid     = 1'b0;
        cmd          = CMD_PUSH;
        sample_ch0   = '0;
        sample_ch1   = '0;
        coef_addr    = '0;
        coef_value   = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_idle = 15;
        recv_idle = 74;

        // full coefficient load, moderate magnitudes
        for (int a = 0; a < COEF_DEPTH; a++)
            send_word(CMD_COEF, '0, '0, COEF_AW'(a),
                      SMP_W'($urandom_range(2097151) - 1048576));

        write_reg(REG_STEP, 32'd268435456);
        write_reg(REG_BYPASS, 32'd0);

        // directed
        send_word(CMD_COEF, '0, '0, 13'd0, 24'sh800000);
        send_word(CMD_COEF, '0, '0, 13'd4127, 24'sh7FFFFF);
        send_word(CMD_COEF, '0, '0, 13'd8191, 24'sh7FFFFF);
        send_word(CMD_COEF, '0, '0, 13'd4128, 24'sh555555);
        for (int i = 0; i < 8; i++)
            send_word(CMD_PUSH, 24'sh7FFFFF, 24'sh800000, '0, '0);
        for (int i = 0; i < 6; i++)
            send_word(CMD_PUSH, 24'sh800000, 24'sh7FFFFF, '0, '0);
        send_word(CMD_PUSH, 24'sh000000, 24'sh555555, '0, '0);
        send_word(CMD_PUSH, 24'shAAAAAA, 24'sh000000, '0, '0);
        for (int i = 0; i < 4; i++)
            send_word(CMD_FLUSH, 24'sh7FFFFF, 24'sh7FFFFF, '0, '0);
        send_word(CMD_CLEAR, '0, '0, '0, '0);
        random_words(30, 80);

        write_reg(REG_STEP, 32'd16777216);
        random_words(30, 80);

        send_idle = 74;
        recv_idle = 15;
        write_reg(REG_STEP, 32'hFFFF_FFFF);
        random_words(40, 90);
        write_reg(REG_BYPASS, 32'd1);
        write_reg(REG_STEP, $urandom);
        random_words(25, 80);

        send_idle = 0;
        recv_idle = 0;
        write_reg(REG_BYPASS, 32'd0);
        write_reg(REG_STEP, $urandom_range(32'd536870912, 32'd67108864));
        random_words(40, 80);

        drain();
        $display("Sent %0d words across five rate/bypass settings; %0d output words checked.",
                 words_sent, sb.matched);
        if (sb.errors == 0 && sb.pending_frames.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/core/pfr_pkg.sv
rtl/core/pfr_coef.sv
rtl/core/pfr_lane.sv
rtl/core/polyphase_fractional_resampler_unit.sv
sim/testbench.sv
